// ===== rtl/mtd_pkg.sv =====
// Shared constants, types and the tanh table for the dense-layer tanh block.
// No dependencies; every other file of the block but mtd_ram imports this package.
package mtd_pkg;

  localparam int MAX_DIM   = 64;
  localparam int ROW_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = 7;
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 12;
  localparam int DATA_W    = 16;
  localparam int Y_W       = 14;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 4 + ROW_W;
  localparam int Q28_W     = 32;
  localparam int Q12_W     = 16;
  localparam int TAB_W     = 12;
  localparam int SAT_Q28   = 1 << 30;
  localparam int ACT_COEF  = 19661;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STATE_DIM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_LEN = 1'd1;

  // command codes
  localparam logic [OP_W-1:0] OP_MAT    = 2'd0;
  localparam logic [OP_W-1:0] OP_STATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ACTION = 2'd2;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd3;

  // pipeline slot kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_ELEM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIAS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              err;
  } issue_t;

  typedef struct packed {
    logic out_busy;
    logic row_done;
  } status_t;

  // tanh at 0.125 steps, unsigned Q0.12
  function automatic logic [TAB_W-1:0] tanh_tab(input logic [ROW_W-1:0] idx);
    logic [TAB_W-1:0] t;
    case (idx)
      6'd0:  t = 12'd0;
      6'd1:  t = 12'd509;
      6'd2:  t = 12'd1003;
      6'd3:  t = 12'd1468;
      6'd4:  t = 12'd1893;
      6'd5:  t = 12'd2272;
      6'd6:  t = 12'd2602;
      6'd7:  t = 12'd2885;
      6'd8:  t = 12'd3119;
      6'd9:  t = 12'd3315;
      6'd10: t = 12'd3475;
      6'd11: t = 12'd3604;
      6'd12: t = 12'd3707;
      6'd13: t = 12'd3790;
      6'd14: t = 12'd3856;
      6'd15: t = 12'd3908;
      6'd16: t = 12'd3949;
      6'd17: t = 12'd3981;
      6'd18: t = 12'd4006;
      6'd19: t = 12'd4026;
      6'd20: t = 12'd4041;
      6'd21: t = 12'd4053;
      6'd22: t = 12'd4063;
      6'd23: t = 12'd4070;
      6'd24: t = 12'd4076;
      6'd25: t = 12'd4080;
      6'd26: t = 12'd4084;
      6'd27: t = 12'd4086;
      6'd28: t = 12'd4089;
      6'd29: t = 12'd4090;
      6'd30: t = 12'd4091;
      6'd31: t = 12'd4092;
      default: t = 12'd4093;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/mtd_cmd_if.sv =====
// Command channel: op, address and value with valid/ready.
// Depends on mtd_pkg.
interface mtd_cmd_if;
  import mtd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        address;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, address, value, input ready);
  modport sink   (input valid, op, address, value, output ready);
endinterface

// ===== rtl/mtd_res_if.sv =====
// Result channel: one next-state element per beat with valid/ready.
// Depends on mtd_pkg.
interface mtd_res_if;
  import mtd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      elem_index;
  logic signed [Y_W-1:0] elem_value;
  logic                  last;
  logic                  error;

  modport source (output valid, elem_index, elem_value, last, error, input ready);
  modport sink   (input valid, elem_index, elem_value, last, error, output ready);
endinterface

// ===== rtl/matvec_tanh_dynamics.sv =====
// Dense layer step next = tanh(M*s + 0.3*a) in Q4.12, with the matrix, state
// and action vectors held in on-chip RAMs. Top level; uses mtd_pkg, the two
// channel interfaces, mtd_ram, mtd_seq and mtd_mac.
//
// Load beats (matrix, state or action entry) are taken one per cycle and
// write straight into their RAM; stores come up undefined and need no
// clearing pass, so the block is ready right after reset. A run beat walks
// the matrix through its single read port, one multiply-accumulate per
// cycle while a row issues: each row issues dim matrix slots and a closing
// slot, and the row total passes the multiply, accumulate, saturate/round
// and tanh stages into the output register; the sequencer then waits until
// that result is taken and the register is empty, which it must be before
// the next row starts. A run with a dimension of zero or above 64 gives a
// single error beat. While a run is in progress no command beat is taken.
module matvec_tanh_dynamics (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtd_pkg::DIM_W-1:0]     cfg_wdata,
  mtd_cmd_if.sink                       cmd,
  mtd_res_if.source                     res
);
  import mtd_pkg::*;

  logic              mat_we, st_we, act_we;
  logic [MAT_AW-1:0] mat_waddr, mat_raddr;
  logic [ROW_W-1:0]  vec_waddr, st_raddr, act_raddr;
  logic [DATA_W-1:0] mat_rdata, st_rdata, act_rdata;
  issue_t            issue;
  status_t           status;

  mtd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .mat_we    (mat_we),
    .mat_waddr (mat_waddr),
    .mat_raddr (mat_raddr),
    .st_we     (st_we),
    .act_we    (act_we),
    .vec_waddr (vec_waddr),
    .st_raddr  (st_raddr),
    .act_raddr (act_raddr),
    .issue     (issue),
    .status    (status)
  );

  mtd_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (cmd.value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mtd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (vec_waddr),
    .wdata (cmd.value),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mtd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (vec_waddr),
    .wdata (cmd.value),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  mtd_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .mat_rdata (mat_rdata),
    .st_rdata  (st_rdata),
    .act_rdata (act_rdata),
    .res       (res),
    .status    (status)
  );

`ifndef SYNTH
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.op == OP_RUN |=> !cmd.ready)
    else $error("command taken in the cycle after a run beat");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    status.row_done |-> !res.valid)
    else $error("row result arrived while the output register was full");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.error |-> res.last && res.elem_index == '0)
    else $error("error beat not marked last at row zero");
`endif
endmodule

// ===== rtl/mtd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/mtd_seq.sv =====
// Sequencer: configuration registers, command intake, store writes and the
// row/column walk that issues one memory read slot per cycle within a row. Uses mtd_pkg.
module mtd_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtd_pkg::DIM_W-1:0]     cfg_wdata,
  mtd_cmd_if.sink                       cmd,
  output logic                          mat_we,
  output logic [mtd_pkg::MAT_AW-1:0]    mat_waddr,
  output logic [mtd_pkg::MAT_AW-1:0]    mat_raddr,
  output logic                          st_we,
  output logic                          act_we,
  output logic [mtd_pkg::ROW_W-1:0]     vec_waddr,
  output logic [mtd_pkg::ROW_W-1:0]     st_raddr,
  output logic [mtd_pkg::ROW_W-1:0]     act_raddr,
  output mtd_pkg::issue_t               issue,
  input  mtd_pkg::status_t              status
);
  import mtd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HOLD  = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]       state;
  logic [DIM_W-1:0] state_dim;
  logic [DIM_W-1:0] action_len;
  logic [DIM_W-1:0] dim;
  logic [DIM_W-1:0] alen;
  logic [ROW_W-1:0] row;
  logic [DIM_W-1:0] col;
  logic [MAT_AW-1:0] flat;
  logic             err_run;

  logic accept;
  logic vec_in_range;
  logic mat_in_range;
  logic dim_bad;
  logic row_last;
  logic col_active;

  assign cmd.ready    = (state == S_IDLE);
  assign accept       = cmd.valid && cmd.ready;
  assign vec_in_range = (cmd.address < ADDR_W'(MAX_DIM));
  assign mat_in_range = ((ADDR_W + 1)'(cmd.address) < (ADDR_W + 1)'(MAT_DEPTH));
  assign dim_bad      = (state_dim == '0) || (state_dim > DIM_W'(MAX_DIM));
  assign row_last     = (DIM_W'(row) == dim - DIM_W'(1));
  assign col_active   = (col < dim);

  assign mat_we    = accept && (cmd.op == OP_MAT) && mat_in_range;
  assign st_we     = accept && (cmd.op == OP_STATE) && vec_in_range;
  assign act_we    = accept && (cmd.op == OP_ACTION) && vec_in_range;
  assign mat_waddr = cmd.address[MAT_AW-1:0];
  assign vec_waddr = cmd.address[ROW_W-1:0];
  assign mat_raddr = flat;
  assign st_raddr  = col[ROW_W-1:0];
  assign act_raddr = row;

  always_comb begin
    issue = '0;
    if (state == S_HOLD && !status.out_busy && err_run) begin
      issue.valid = 1'b1;
      issue.kind  = KIND_ERR;
      issue.last  = 1'b1;
      issue.err   = 1'b1;
    end else if (state == S_ISSUE) begin
      issue.valid = 1'b1;
      issue.row   = row;
      if (col_active) begin
        issue.kind = KIND_ELEM;
      end else begin
        issue.kind = (DIM_W'(row) < alen) ? KIND_BIAS : KIND_NONE;
        issue.last = row_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_dim  <= '0;
      action_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATE_DIM:  state_dim  <= cfg_wdata;
        REG_ACTION_LEN: action_len <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      err_run <= 1'b0;
      dim     <= '0;
      alen    <= '0;
      row     <= '0;
      col     <= '0;
      flat    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.op == OP_RUN) begin
            dim     <= state_dim;
            alen    <= action_len;
            err_run <= dim_bad;
            row     <= '0;
            col     <= '0;
            flat    <= '0;
            state   <= S_HOLD;
          end
        end
        S_HOLD: begin
          // start a row only once the previous result has left
          if (!status.out_busy) begin
            state <= err_run ? S_WAIT : S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (col_active) begin
            col  <= col + DIM_W'(1);
            flat <= flat + MAT_AW'(1);
          end else begin
            col   <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (status.row_done) begin
            if (err_run || row_last) begin
              state <= S_IDLE;
            end else begin
              row   <= row + ROW_W'(1);
              state <= S_HOLD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/mtd_mac.sv =====
// Datapath: multiply, accumulate, saturate/round to Q4.12, tanh by table
// interpolation and the result register. Uses mtd_pkg and mtd_res_if.
module mtd_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  mtd_pkg::issue_t                   issue,
  input  logic signed [mtd_pkg::DATA_W-1:0] mat_rdata,
  input  logic signed [mtd_pkg::DATA_W-1:0] st_rdata,
  input  logic signed [mtd_pkg::DATA_W-1:0] act_rdata,
  mtd_res_if.source                         res,
  output mtd_pkg::status_t                  status
);
  import mtd_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_POS = ACC_W'(SAT_Q28);
  localparam logic signed [ACC_W-1:0] SAT_NEG = -SAT_POS;
  localparam logic signed [DATA_W-1:0] COEF   = DATA_W'(ACT_COEF);

  issue_t                    tag_a, tag_b, tag_c, tag_d, tag_e;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   sum;
  logic signed [Q12_W-1:0]   q12;
  logic signed [Y_W-1:0]     y;

  logic                      out_valid;
  logic [ROW_W-1:0]          out_index;
  logic signed [Y_W-1:0]     out_value;
  logic                      out_last;
  logic                      out_err;

  logic signed [DATA_W-1:0]  opa, opb;
  logic signed [ACC_W-1:0]   prod_ext, term;
  logic signed [Q28_W-1:0]   clamped, rnd;
  logic                      neg;
  logic [Q12_W-1:0]          mag;
  logic [ROW_W-1:0]          idx;
  logic [8:0]                frac;
  logic [TAB_W-1:0]          base, diff;
  logic [TAB_W+9:0]          interp;
  logic [TAB_W-1:0]          y_mag;

  assign opa = (tag_a.kind == KIND_ELEM) ? mat_rdata : act_rdata;
  assign opb = (tag_a.kind == KIND_ELEM) ? st_rdata : COEF;

  assign prod_ext = ACC_W'(prod);
  always_comb begin
    case (tag_b.kind)
      KIND_ELEM: term = prod_ext <<< 4;
      KIND_BIAS: term = prod_ext;
      default:   term = '0;
    endcase
  end

  always_comb begin
    if (sum > SAT_POS) begin
      clamped = Q28_W'(SAT_POS);
    end else if (sum < SAT_NEG) begin
      clamped = Q28_W'(SAT_NEG);
    end else begin
      clamped = Q28_W'(sum);
    end
    // round half up, then drop the 16 fraction bits
    rnd = clamped + Q28_W'(32'sd32768);
  end

  always_comb begin
    neg    = q12[Q12_W-1];
    mag    = neg ? Q12_W'(-q12) : Q12_W'(q12);
    idx    = mag[14:9];
    frac   = mag[8:0];
    base   = tanh_tab(idx);
    diff   = tanh_tab(idx + ROW_W'(1)) - base;
    interp = (TAB_W + 10)'(diff) * (TAB_W + 10)'(frac) + (TAB_W + 10)'(256);
    if (idx >= ROW_W'(32)) begin
      y_mag = tanh_tab(ROW_W'(32));
    end else begin
      y_mag = base + interp[TAB_W+8:9];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a.valid <= 1'b0;
      tag_b.valid <= 1'b0;
      tag_c.valid <= 1'b0;
      tag_d.valid <= 1'b0;
      tag_e.valid <= 1'b0;
      acc         <= '0;
      sum         <= '0;
    end else begin
      tag_a <= issue;
      tag_b <= tag_a;
      tag_d <= tag_c;
      tag_e <= tag_d;
      if (tag_b.valid && tag_b.kind != KIND_ELEM) begin
        tag_c <= tag_b;
      end else begin
        tag_c <= '0;
      end
      if (tag_b.valid) begin
        if (tag_b.kind == KIND_ELEM) begin
          acc <= acc + term;
        end else begin
          // closing slot of a row: hand the total on and clear
          sum <= acc + term;
          acc <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    q12  <= rnd[Q28_W-1:16];
    y    <= neg ? -Y_W'(y_mag) : Y_W'(y_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tag_e.valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_e.valid) begin
      out_index <= tag_e.row;
      out_value <= y;
      out_last  <= tag_e.last;
      out_err   <= tag_e.err;
    end
  end

  assign res.valid      = out_valid;
  assign res.elem_index = out_index;
  assign res.elem_value = out_value;
  assign res.last       = out_last;
  assign res.error      = out_err;

  assign status.out_busy = out_valid;
  assign status.row_done = tag_e.valid;
endmodule
